// ===== rtl/drd_pkg.sv =====
// Shared types, register indexes and reset values for the detection row decoder.
package drd_pkg;

    localparam int SCORE_W     = 16;
    localparam int COORD_W     = 16;
    localparam int INPUT_LANES = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int CLASS_CNT_W = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_CLASS_COUNT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCORE_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_X           = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAD_Y           = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_SCALE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_OFFSET      = 3'd5;

    localparam logic [CLASS_CNT_W-1:0] RST_CLASS_COUNT     = 9'd16;
    localparam logic [SCORE_W-1:0]     RST_SCORE_THRESHOLD = 16'd16384;
    localparam logic [23:0]            RST_INVERSE_SCALE   = 24'd65536;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] width_in;
        logic [COORD_W-1:0] height_in;
        logic [SCORE_W-1:0] score_a;
        logic [SCORE_W-1:0] score_b;
        logic [SCORE_W-1:0] score_c;
        logic [SCORE_W-1:0] score_d;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic signed [15:0] box_width;
        logic signed [15:0] box_height;
        logic [SCORE_W-1:0] confidence;
        logic [7:0]         class_index;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] width_in;
        logic [COORD_W-1:0] height_in;
        logic [SCORE_W-1:0] confidence;
        logic [7:0]         class_index;
    } t_row;

    typedef struct packed {
        logic [9:0]  pad_x;
        logic [9:0]  pad_y;
        logic [23:0] inverse_scale;
        logic [14:0] row_offset;
    } t_scale_cfg;

endpackage

// ===== rtl/drd_lane.sv =====
// One score lane: qualifies a class score against the configured class count.
module drd_lane #(
    parameter int CNT_W = 9
) (
    input  logic [drd_pkg::SCORE_W-1:0] i_score,
    input  logic [CNT_W-1:0]            i_class,
    input  logic [CNT_W-1:0]            i_class_count,
    output logic                        o_valid,
    output logic [drd_pkg::SCORE_W-1:0] o_score
);

    // Classes past the end of the row take no part in the search.
    assign o_valid = (i_class < i_class_count);
    assign o_score = o_valid ? i_score : '0;

endmodule

// ===== rtl/drd_merge.sv =====
// Comparison tree that picks the highest lane score, the lower lane winning a tie.
module drd_merge #(
    parameter int LANES  = 4,
    parameter int LANE_W = 2
) (
    input  logic [LANES-1:0]            i_valid,
    input  logic [drd_pkg::SCORE_W-1:0] i_score [LANES],
    output logic                        o_valid,
    output logic [drd_pkg::SCORE_W-1:0] o_score,
    output logic [LANE_W-1:0]           o_lane
);

    localparam int P2    = 1 << $clog2(LANES);
    localparam int NODES = 2 * P2 - 1;

    logic                        nd_valid [NODES];
    logic [drd_pkg::SCORE_W-1:0] nd_score [NODES];
    logic [LANE_W-1:0]           nd_lane  [NODES];

    always_comb begin
        for (int i = 0; i < P2; i++) begin
            if (i < LANES) begin
                nd_valid[P2-1+i] = i_valid[i];
                nd_score[P2-1+i] = i_score[i];
            end else begin
                nd_valid[P2-1+i] = 1'b0;
                nd_score[P2-1+i] = '0;
            end
            nd_lane[P2-1+i] = LANE_W'(i);
        end
        // The right child holds higher lanes, so it wins only on a strictly higher score.
        for (int i = P2 - 2; i >= 0; i--) begin
            if (nd_valid[2*i+2] &&
                (!nd_valid[2*i+1] || (nd_score[2*i+2] > nd_score[2*i+1]))) begin
                nd_valid[i] = 1'b1;
                nd_score[i] = nd_score[2*i+2];
                nd_lane[i]  = nd_lane[2*i+2];
            end else begin
                nd_valid[i] = nd_valid[2*i+1];
                nd_score[i] = nd_score[2*i+1];
                nd_lane[i]  = nd_lane[2*i+1];
            end
        end
    end

    assign o_valid = nd_valid[0];
    assign o_score = nd_score[0];
    assign o_lane  = nd_lane[0];

endmodule

// ===== rtl/drd_scale.sv =====
// Box mapping pipeline: multiply stage, then truncation, saturation and output register.
module drd_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  drd_pkg::t_row       i_row,
    input  drd_pkg::t_scale_cfg i_cfg,
    output logic                o_valid,
    input  logic                i_ready,
    output drd_pkg::t_out_item  o_item
);

    // Truncates toward zero after dropping sh fraction bits, then clamps to 16 bits.
    function automatic logic signed [15:0] f_trunc_sat(input logic signed [43:0] v,
                                                       input int unsigned sh);
        logic        [43:0] mask;
        logic signed [43:0] q;
        logic               inexact;
        mask    = (44'd1 << sh) - 44'd1;
        inexact = |($unsigned(v) & mask);
        q       = v >>> sh;
        if (v[43] && inexact) begin
            q = q + 44'sd1;
        end
        if (q > 44'sd32767) begin
            return 16'sh7FFF;
        end else if (q < -44'sd32768) begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

    logic signed [17:0] w_nx;
    logic signed [17:0] w_ny;
    logic signed [24:0] w_inv;
    logic               w_o_ready;
    logic               w_m_take;
    logic signed [43:0] w_top_sum;

    logic               r_m_valid;
    logic signed [42:0] r_m_px;
    logic signed [42:0] r_m_py;
    logic [39:0]        r_m_pw;
    logic [39:0]        r_m_ph;
    logic [15:0]        r_m_score;
    logic [7:0]         r_m_class;

    logic               r_o_valid;
    drd_pkg::t_out_item r_o_item;

    // Edge offsets in units of 1/32 pixel: 2*center - size - 32*pad.
    assign w_nx  = $signed({1'b0, i_row.center_x, 1'b0}) - $signed({2'b00, i_row.width_in})
                 - $signed({3'b000, i_cfg.pad_x, 5'b00000});
    assign w_ny  = $signed({1'b0, i_row.center_y, 1'b0}) - $signed({2'b00, i_row.height_in})
                 - $signed({3'b000, i_cfg.pad_y, 5'b00000});
    assign w_inv = $signed({1'b0, i_cfg.inverse_scale});

    assign w_o_ready = !r_o_valid || i_ready;
    assign w_m_take  = r_m_valid && w_o_ready;
    assign o_ready   = !r_m_valid || w_m_take;

    assign w_top_sum = 44'(r_m_py) + $signed({8'd0, i_cfg.row_offset, 21'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_ready) begin
            r_m_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_m_px    <= w_nx * w_inv;
            r_m_py    <= w_ny * w_inv;
            r_m_pw    <= i_row.width_in * i_cfg.inverse_scale;
            r_m_ph    <= i_row.height_in * i_cfg.inverse_scale;
            r_m_score <= i_row.confidence;
            r_m_class <= i_row.class_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_ready) begin
            r_o_valid <= r_m_valid;
        end
        if (w_m_take) begin
            r_o_item.box_left    <= f_trunc_sat(44'(r_m_px), 21);
            r_o_item.box_top     <= f_trunc_sat(w_top_sum, 21);
            r_o_item.box_width   <= f_trunc_sat($signed({4'd0, r_m_pw}), 20);
            r_o_item.box_height  <= f_trunc_sat($signed({4'd0, r_m_ph}), 20);
            r_o_item.confidence  <= r_m_score;
            r_o_item.class_index <= r_m_class;
        end
    end

    assign o_valid = r_o_valid;
    assign o_item  = r_o_item;

endmodule

// ===== rtl/detection_row_decoder.sv =====
// Top level of the detection row decoder: configuration, row accumulation and box output.
//
// Usage: a detection row enters on the input channel as a run of transfers (beats), one
// per cycle at most, each with SCORE_LANES class scores; lane l of beat b is class
// b*SCORE_LANES + l. The box fields are sampled on the first beat of a row only. A row
// spans ceil(class_count / SCORE_LANES) beats. A row whose best score reaches the
// threshold yields one transfer on the output channel; other rows yield nothing.
// Throughput: one beat per cycle, with no gap between rows, unless a row's last beat is
// held back as below. The result of a row is offered once it has passed from the row
// register through the multiply stage into the output register.
// The score search itself is a compare tree across the lanes plus one compare against the
// running best, done in the cycle a beat is taken.
// Stalls: when the receiver holds ready low the output register keeps its transfer; the
// two stages behind it still absorb finished rows, and only a row's last beat is held
// back once all of them are full. Non-final beats are always taken.
// Reset (synchronous, active low) empties the pipeline, starts a new row and restores
// the register defaults. Configuration writes take effect on the next cycle and are
// expected only while no row is in flight.
module detection_row_decoder #(
    parameter int MAX_CLASSES = 256,
    parameter int SCORE_LANES = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  drd_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output drd_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [drd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int BEATS  = (MAX_CLASSES + SCORE_LANES - 1) / SCORE_LANES;
    localparam int BEAT_W = (BEATS > 1) ? $clog2(BEATS) : 1;
    localparam int CNT_W  = $clog2(BEATS * SCORE_LANES + 1);
    localparam int CLS_W  = $clog2(MAX_CLASSES);
    localparam int CLSX_W = (CLS_W > 8) ? CLS_W : 8;
    localparam int LANE_W = (SCORE_LANES > 1) ? $clog2(SCORE_LANES) : 1;

    // Configuration registers.
    logic [drd_pkg::CLASS_CNT_W-1:0] r_class_count;
    logic [drd_pkg::SCORE_W-1:0]     r_score_threshold;
    drd_pkg::t_scale_cfg             r_scale_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count             <= drd_pkg::RST_CLASS_COUNT;
            r_score_threshold         <= drd_pkg::RST_SCORE_THRESHOLD;
            r_scale_cfg.pad_x         <= '0;
            r_scale_cfg.pad_y         <= '0;
            r_scale_cfg.inverse_scale <= drd_pkg::RST_INVERSE_SCALE;
            r_scale_cfg.row_offset    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                drd_pkg::REG_CLASS_COUNT:     r_class_count <= i_cfg_data[8:0];
                drd_pkg::REG_SCORE_THRESHOLD: r_score_threshold <= i_cfg_data[15:0];
                drd_pkg::REG_PAD_X:           r_scale_cfg.pad_x <= i_cfg_data[9:0];
                drd_pkg::REG_PAD_Y:           r_scale_cfg.pad_y <= i_cfg_data[9:0];
                drd_pkg::REG_INVERSE_SCALE:   r_scale_cfg.inverse_scale <= i_cfg_data[23:0];
                drd_pkg::REG_ROW_OFFSET:      r_scale_cfg.row_offset <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // A class count of zero acts as one; counts above the build limit are clamped.
    logic [31:0]      w_cc32;
    logic [31:0]      w_eff32;
    logic [CNT_W-1:0] w_eff_classes;

    always_comb begin
        w_cc32 = 32'(r_class_count);
        if (w_cc32 == 32'd0) begin
            w_eff32 = 32'd1;
        end else if (w_cc32 > 32'(MAX_CLASSES)) begin
            w_eff32 = 32'(MAX_CLASSES);
        end else begin
            w_eff32 = w_cc32;
        end
    end
    assign w_eff_classes = w_eff32[CNT_W-1:0];

    // Row position. The row ends on the beat whose lanes reach the class count, which
    // also covers a class count lowered in the middle of a row.
    logic [BEAT_W-1:0] r_beat;
    logic [CNT_W-1:0]  w_base;
    logic              w_first;
    logic              w_last;
    logic              w_accept;

    assign w_base   = CNT_W'(r_beat) * CNT_W'(SCORE_LANES);
    assign w_first  = (r_beat == '0);
    assign w_last   = ((w_base + CNT_W'(SCORE_LANES)) >= w_eff_classes);
    assign w_accept = i_in_valid && o_in_ready;

    // Lanes: scores beyond the four carried by the input read as zero.
    logic [drd_pkg::SCORE_W-1:0] w_in_scores   [drd_pkg::INPUT_LANES];
    logic [drd_pkg::SCORE_W-1:0] w_lane_in     [SCORE_LANES];
    logic [drd_pkg::SCORE_W-1:0] w_lane_score  [SCORE_LANES];
    logic [SCORE_LANES-1:0]      w_lane_valid;

    assign w_in_scores[0] = i_in_item.score_a;
    assign w_in_scores[1] = i_in_item.score_b;
    assign w_in_scores[2] = i_in_item.score_c;
    assign w_in_scores[3] = i_in_item.score_d;

    for (genvar g = 0; g < SCORE_LANES; g++) begin : g_lane
        if (g < drd_pkg::INPUT_LANES) begin : g_fed
            assign w_lane_in[g] = w_in_scores[g];
        end else begin : g_unfed
            assign w_lane_in[g] = '0;
        end

        drd_lane #(
            .CNT_W(CNT_W)
        ) u_lane (
            .i_score      (w_lane_in[g]),
            .i_class      (w_base + CNT_W'(g)),
            .i_class_count(w_eff_classes),
            .o_valid      (w_lane_valid[g]),
            .o_score      (w_lane_score[g])
        );
    end

    logic                        w_win_valid;
    logic [drd_pkg::SCORE_W-1:0] w_win_score;
    logic [LANE_W-1:0]           w_win_lane;
    logic [CNT_W-1:0]            w_win_class;

    drd_merge #(
        .LANES (SCORE_LANES),
        .LANE_W(LANE_W)
    ) u_merge (
        .i_valid(w_lane_valid),
        .i_score(w_lane_score),
        .o_valid(w_win_valid),
        .o_score(w_win_score),
        .o_lane (w_win_lane)
    );

    assign w_win_class = w_base + CNT_W'(w_win_lane);

    // Running best: the first beat of a row always loads; later beats need a strictly
    // higher score, so the earliest class keeps a tie.
    logic [drd_pkg::SCORE_W-1:0] r_best_score;
    logic [CLS_W-1:0]            r_best_class;
    logic [drd_pkg::SCORE_W-1:0] n_best_score;
    logic [CLS_W-1:0]            n_best_class;
    logic [CLSX_W-1:0]           w_class_ext;

    always_comb begin
        n_best_score = r_best_score;
        n_best_class = r_best_class;
        if (w_first || (w_win_valid && (w_win_score > r_best_score))) begin
            n_best_score = w_win_score;
            n_best_class = w_win_class[CLS_W-1:0];
        end
    end
    assign w_class_ext = CLSX_W'(n_best_class);

    // Box fields held from the first beat.
    logic [drd_pkg::COORD_W-1:0] r_held_cx;
    logic [drd_pkg::COORD_W-1:0] r_held_cy;
    logic [drd_pkg::COORD_W-1:0] r_held_w;
    logic [drd_pkg::COORD_W-1:0] r_held_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat       <= '0;
            r_best_score <= '0;
            r_best_class <= '0;
        end else if (w_accept) begin
            r_best_score <= n_best_score;
            r_best_class <= n_best_class;
            r_beat       <= w_last ? '0 : r_beat + BEAT_W'(1);
        end
        if (w_accept && w_first) begin
            r_held_cx <= i_in_item.center_x;
            r_held_cy <= i_in_item.center_y;
            r_held_w  <= i_in_item.width_in;
            r_held_h  <= i_in_item.height_in;
        end
    end

    // Finished-row register. Rows under the threshold drain from here without a result.
    logic          r_s1_valid;
    drd_pkg::t_row r_s1_row;
    logic          w_s1_pass;
    logic          w_s1_take;
    logic          w_s1_ready;
    logic          w_scale_ready;

    assign w_s1_pass  = (r_s1_row.confidence >= r_score_threshold);
    assign w_s1_take  = r_s1_valid && (!w_s1_pass || w_scale_ready);
    assign w_s1_ready = !r_s1_valid || w_s1_take;
    assign o_in_ready = !w_last || w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept && w_last) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_take) begin
            r_s1_valid <= 1'b0;
        end
        if (w_accept && w_last) begin
            r_s1_row.center_x    <= w_first ? i_in_item.center_x  : r_held_cx;
            r_s1_row.center_y    <= w_first ? i_in_item.center_y  : r_held_cy;
            r_s1_row.width_in    <= w_first ? i_in_item.width_in  : r_held_w;
            r_s1_row.height_in   <= w_first ? i_in_item.height_in : r_held_h;
            r_s1_row.confidence  <= n_best_score;
            r_s1_row.class_index <= w_class_ext[7:0];
        end
    end

    drd_scale u_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_s1_valid && w_s1_pass),
        .o_ready(w_scale_ready),
        .i_row  (r_s1_row),
        .i_cfg  (r_scale_cfg),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_item (o_out_item)
    );

endmodule

// ===== rtl/drd_checker.sv =====
// Port-level checks on the result channel of the detection row decoder, with its bind.
module drd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  drd_pkg::t_out_item i_out_item
);

    // The result is held until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_item))
        else $error("result changed while stalled");

    // Width and height come from unsigned sizes and can never be negative.
    a_size_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_out_item.box_width[15] && !i_out_item.box_height[15]))
        else $error("negative box size");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind detection_row_decoder drd_checker u_drd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .i_out_item (o_out_item)
);
